// ----- design/sds_pkg.sv -----
// ---------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the storage directory selector.
// ---------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  localparam int NUM_DIRS = 16;
  localparam int DIR_W    = $clog2(NUM_DIRS);
  localparam int CNT_W    = DIR_W + 1;

  // fixed field widths
  localparam int ACT_W    = 5;
  localparam int LOAD_W   = 17;
  localparam int SPACE_W  = 32;
  localparam int MINOBJ_W = 47;
  localparam int OBJ_W    = 48;
  localparam int HDR_W    = 16;
  localparam int RRLD_W   = 16;
  localparam int SIZE_W   = OBJ_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RRLD_W-1:0] LL_MAX_LOAD     = RRLD_W'(1000);
  localparam logic [RRLD_W-1:0] RR_MAX_LOAD_RST = RRLD_W'(1000);
  localparam logic [ACT_W-1:0]  ACTIVE_RST      = ACT_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RR_MAX_LOAD  = 2'd2;

  localparam logic MODE_LEAST_LOAD  = 1'b0;
  localparam logic MODE_ROUND_ROBIN = 1'b1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SELECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic read_only;
    logic accepts;
    logic [LOAD_W-1:0]   load;
    logic [SPACE_W-1:0]  used;
    logic [SPACE_W-1:0]  capacity;
    logic [MINOBJ_W-1:0] min_object;
    logic [OBJ_W-1:0]    max_object;
  } entry_t;

  typedef struct packed {
    logic write;
    logic init;
    logic advance;
    logic eval;
  } dp_cmd_t;

  typedef struct packed {
    logic             n_zero;
    logic             hit;
    logic [CNT_W-1:0] looks_m1;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/sds_ctrl.sv -----
// ---------------------------------------------------------------------------
// sds_ctrl
// Sequencer: accepts words, steps the table scan, issues the result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module sds_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             req_type,
  input  wire sds_pkg::dp_sts_t sts,
  output sds_pkg::dp_cmd_t      cmd,
  output logic                  busy,
  output logic                  out_strobe
);

  sds_pkg::state_t state_r, state_nxt;
  logic [sds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic accept;

  assign accept = start && (state_r == sds_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      sds_pkg::ST_IDLE: begin
        if (accept && req_type == sds_pkg::REQ_SELECT) begin
          state_nxt = sts.n_zero ? sds_pkg::ST_DONE : sds_pkg::ST_LOAD;
        end
      end
      sds_pkg::ST_LOAD: begin
        state_nxt = sds_pkg::ST_SCAN;
        cnt_nxt   = '0;
      end
      sds_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (sts.hit || cnt_r == sts.looks_m1) begin
          state_nxt = sds_pkg::ST_DONE;
        end
      end
      sds_pkg::ST_DONE: begin
        state_nxt = sds_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sds_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    busy        = 1'b1;
    out_strobe  = 1'b0;
    case (state_r)
      sds_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.write   = accept && req_type == sds_pkg::REQ_WRITE;
        cmd.init    = accept && req_type == sds_pkg::REQ_SELECT;
      end
      sds_pkg::ST_LOAD: begin
        cmd.advance = 1'b1;
      end
      sds_pkg::ST_SCAN: begin
        cmd.advance = 1'b1;
        cmd.eval    = 1'b1;
      end
      sds_pkg::ST_DONE: begin
        out_strobe  = 1'b1;
      end
      default: begin
        busy        = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/sds_datapath.sv -----
// ---------------------------------------------------------------------------
// sds_datapath
// Directory table, configuration registers, eligibility check and best-pick
// tracking for both selection modes.
// ---------------------------------------------------------------------------
`default_nettype none

module sds_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sds_pkg::dp_cmd_t                cmd,
  output sds_pkg::dp_sts_t                     sts,
  input  wire logic                            cfg_wr,
  input  wire logic [sds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [sds_pkg::DIR_W-1:0]       in_dir_index,
  input  wire logic                            in_read_only,
  input  wire logic                            in_accepts,
  input  wire logic signed [sds_pkg::LOAD_W-1:0]   in_load,
  input  wire logic [sds_pkg::SPACE_W-1:0]     in_used_space,
  input  wire logic [sds_pkg::SPACE_W-1:0]     in_capacity,
  input  wire logic [sds_pkg::MINOBJ_W-1:0]    in_min_object,
  input  wire logic signed [sds_pkg::OBJ_W-1:0]    in_max_object,
  input  wire logic signed [sds_pkg::OBJ_W-1:0]    in_object_size,
  input  wire logic [sds_pkg::HDR_W-1:0]       in_header_size,
  output logic                                 out_found,
  output logic [sds_pkg::DIR_W-1:0]            out_chosen_dir
);

  localparam int DIR_W  = sds_pkg::DIR_W;
  localparam int CNT_W  = sds_pkg::CNT_W;
  localparam int SIZE_W = sds_pkg::SIZE_W;
  localparam int OBJ_W  = sds_pkg::OBJ_W;

  // configuration
  logic                          mode_r;
  logic [sds_pkg::ACT_W-1:0]     active_r;
  logic [sds_pkg::RRLD_W-1:0]    rr_max_r;

  // table and read port
  sds_pkg::entry_t mem [sds_pkg::NUM_DIRS];
  sds_pkg::entry_t rd_r;
  logic [DIR_W-1:0] addr_r, addr_nxt, eval_addr_r;

  // per-select context
  logic                     sel_mode_r;
  logic [CNT_W-1:0]         n_r;
  logic signed [SIZE_W-1:0] size_r;
  logic                     unk_r;
  logic [DIR_W-1:0]         rr_ptr_r;

  // best candidate so far
  logic                              have_r;
  logic [DIR_W-1:0]                  best_idx_r;
  logic [sds_pkg::RRLD_W-1:0]        best_load_r;
  logic signed [OBJ_W-1:0]           best_max_r;
  logic [sds_pkg::SPACE_W-1:0]       best_free_r;

  logic [CNT_W-1:0]         n_cfg;
  logic signed [SIZE_W-1:0] obj_ext, size_init;
  logic                     obj_unk;
  logic signed [SIZE_W-1:0] min_ext, max_ext;
  logic                     max_unl, fits, base_ok, load_nonneg;
  logic                     rr_ok, ll_ok, ll_take, tie_keep;
  logic [sds_pkg::RRLD_W-1:0]  ld;
  logic [sds_pkg::SPACE_W-1:0] free_sp;

  function automatic logic [DIR_W-1:0] wrap_next(input logic [DIR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] inc;
    inc = {1'b0, p} + CNT_W'(1);
    wrap_next = (inc >= n) ? '0 : inc[DIR_W-1:0];
  endfunction

  assign n_cfg = (active_r > sds_pkg::ACT_W'(sds_pkg::NUM_DIRS)) ?
                 CNT_W'(sds_pkg::NUM_DIRS) : CNT_W'(active_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sds_pkg::MODE_LEAST_LOAD;
      active_r <= sds_pkg::ACTIVE_RST;
      rr_max_r <= sds_pkg::RR_MAX_LOAD_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        sds_pkg::CFG_SELECT_MODE:  mode_r   <= cfg_data[0];
        sds_pkg::CFG_ACTIVE_COUNT: active_r <= cfg_data[sds_pkg::ACT_W-1:0];
        sds_pkg::CFG_RR_MAX_LOAD:  rr_max_r <= cfg_data[sds_pkg::RRLD_W-1:0];
        default: ;
      endcase
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[in_dir_index] <= '{read_only:  in_read_only,
                             accepts:    in_accepts,
                             load:       in_load,
                             used:       in_used_space,
                             capacity:   in_capacity,
                             min_object: in_min_object,
                             max_object: in_max_object};
    end
    rd_r        <= mem[addr_r];
    eval_addr_r <= addr_r;
  end

  // object size: header added only for a known size in least-load mode
  assign obj_ext   = SIZE_W'(in_object_size);
  assign obj_unk   = (in_object_size == -OBJ_W'(1));
  assign size_init = (mode_r == sds_pkg::MODE_LEAST_LOAD && !obj_unk) ?
                     obj_ext + $signed({{(SIZE_W-sds_pkg::HDR_W){1'b0}}, in_header_size}) :
                     obj_ext;

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.init) begin
      addr_nxt = (mode_r == sds_pkg::MODE_ROUND_ROBIN) ? wrap_next(rr_ptr_r, n_cfg) : '0;
    end else if (cmd.advance) begin
      addr_nxt = (sel_mode_r == sds_pkg::MODE_ROUND_ROBIN) ? wrap_next(addr_r, n_r) :
                 addr_r + DIR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (cmd.init) begin
      sel_mode_r <= mode_r;
      n_r        <= n_cfg;
      size_r     <= size_init;
      unk_r      <= obj_unk;
    end
  end

  // eligibility of the entry in the read register
  assign min_ext     = $signed({{(SIZE_W-sds_pkg::MINOBJ_W){1'b0}}, rd_r.min_object});
  assign max_ext     = SIZE_W'($signed(rd_r.max_object));
  assign max_unl     = ($signed(rd_r.max_object) == -OBJ_W'(1));
  assign fits        = unk_r ? max_unl :
                       ((min_ext <= size_r) && (max_ext > size_r || max_unl));
  assign base_ok     = !rd_r.read_only && rd_r.accepts &&
                       (rd_r.used <= rd_r.capacity) && fits;
  assign load_nonneg = !rd_r.load[sds_pkg::LOAD_W-1];
  assign ld          = rd_r.load[sds_pkg::RRLD_W-1:0];
  assign rr_ok       = base_ok && load_nonneg && (ld <= rr_max_r);
  assign ll_ok       = base_ok && load_nonneg && (ld <= sds_pkg::LL_MAX_LOAD);
  assign free_sp     = rd_r.capacity - rd_r.used;

  // on equal load: keep the earlier pick against a looser size limit or less free space
  assign tie_keep = (best_max_r != -OBJ_W'(1) &&
                     ($signed(rd_r.max_object) > best_max_r || max_unl)) ||
                    (free_sp < best_free_r);
  assign ll_take  = ll_ok && (!have_r || ld < best_load_r ||
                              (ld == best_load_r && !tie_keep));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_ptr_r <= '0;
      have_r   <= 1'b0;
    end else if (cmd.init) begin
      have_r   <= 1'b0;
    end else if (cmd.eval) begin
      if (sel_mode_r == sds_pkg::MODE_ROUND_ROBIN) begin
        rr_ptr_r <= eval_addr_r;
        if (rr_ok) begin
          have_r <= 1'b1;
        end
      end else if (ll_take) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best_idx_r <= '0;
    end else if (cmd.eval) begin
      if (sel_mode_r == sds_pkg::MODE_ROUND_ROBIN) begin
        if (rr_ok) begin
          best_idx_r <= eval_addr_r;
        end
      end else if (ll_take) begin
        best_idx_r  <= eval_addr_r;
        best_load_r <= ld;
        best_max_r  <= $signed(rd_r.max_object);
        best_free_r <= free_sp;
      end
    end
  end

  assign sts.n_zero   = (n_cfg == '0);
  assign sts.hit      = (sel_mode_r == sds_pkg::MODE_ROUND_ROBIN) && rr_ok;
  assign sts.looks_m1 = (sel_mode_r == sds_pkg::MODE_ROUND_ROBIN) ? n_r : n_r - CNT_W'(1);

  assign out_found      = have_r;
  assign out_chosen_dir = have_r ? best_idx_r : '0;

endmodule

`default_nettype wire

// ----- design/store_dir_selector_core.sv -----
// ---------------------------------------------------------------------------
// store_dir_selector_core
// Picks a storage directory from a table of up to NUM_DIRS entries.
// ---------------------------------------------------------------------------
// An update word (in_req_type = 0) is written into the table and busy stays low,
// so another word may follow at once. A select word scans the table through
// its single registered read port, one entry per cycle, with n = active_count
// (saturated to NUM_DIRS); busy stays high until the result. Round-robin mode
// stops at the first eligible entry; with n = 0 no entry is scanned. The result
// is valid on out_found and out_chosen_dir while out_strobe is high for exactly
// one cycle, in the last busy cycle; the receiver cannot stall it.
// Configuration is always ready and must be written only while busy is low.
// ---------------------------------------------------------------------------
`default_nettype none

module store_dir_selector_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_req_type,
  input  wire logic [sds_pkg::DIR_W-1:0]          in_dir_index,
  input  wire logic                               in_read_only,
  input  wire logic                               in_accepts,
  input  wire logic signed [sds_pkg::LOAD_W-1:0]  in_load,
  input  wire logic [sds_pkg::SPACE_W-1:0]        in_used_space,
  input  wire logic [sds_pkg::SPACE_W-1:0]        in_capacity,
  input  wire logic [sds_pkg::MINOBJ_W-1:0]       in_min_object,
  input  wire logic signed [sds_pkg::OBJ_W-1:0]   in_max_object,
  input  wire logic signed [sds_pkg::OBJ_W-1:0]   in_object_size,
  input  wire logic [sds_pkg::HDR_W-1:0]          in_header_size,
  output logic                                    out_strobe,
  output logic                                    out_found,
  output logic [sds_pkg::DIR_W-1:0]               out_chosen_dir,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sds_pkg::dp_cmd_t cmd;
  sds_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  sds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  sds_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_dir_index   (in_dir_index),
    .in_read_only   (in_read_only),
    .in_accepts     (in_accepts),
    .in_load        (in_load),
    .in_used_space  (in_used_space),
    .in_capacity    (in_capacity),
    .in_min_object  (in_min_object),
    .in_max_object  (in_max_object),
    .in_object_size (in_object_size),
    .in_header_size (in_header_size),
    .out_found      (out_found),
    .out_chosen_dir (out_chosen_dir)
  );

endmodule

`default_nettype wire

// ----- design/sds_checker.sv -----
// ---------------------------------------------------------------------------
// sds_checker
// Port-level checks of the selector's command and result timing.
// ---------------------------------------------------------------------------
`default_nettype none

module sds_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      in_req_type,
  input wire logic                      out_strobe,
  input wire logic                      out_found,
  input wire logic [sds_pkg::DIR_W-1:0] out_chosen_dir
);

  // a result only closes a select that is still in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe not followed by idle");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_chosen_dir == '0))
    else $error("chosen_dir not zero on empty result");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == sds_pkg::REQ_WRITE) |=> (!busy && !out_strobe))
    else $error("update word made the block busy");

  a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == sds_pkg::REQ_SELECT) |=> busy)
    else $error("select word not taken");

endmodule

bind store_dir_selector_core sds_checker u_sds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_strobe     (out_strobe),
  .out_found      (out_found),
  .out_chosen_dir (out_chosen_dir)
);

`default_nettype wire

// ----- tb/sv/store_dir_selector_core_tb.sv -----
// ---------------------------------------------------------------------------
// store_dir_selector_core_tb
// Self-checking bench for the storage directory selector. Table writes and
// select words go in through the start/busy port. A scoreboard model of the
// table, the round-robin pointer and the register set predicts every choice.
// A monitor compares each strobed result against the oldest prediction.
// The run has directed cases for reset state, least-load tie breaking and
// the round-robin pointer, then random traffic over several register
// settings and sender idle rates.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module store_dir_selector_core_tb;
  import sds_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    bit                        req;
    bit [DIR_W-1:0]            dir;
    bit                        ro;
    bit                        acc;
    bit signed [LOAD_W-1:0]    load;
    bit [SPACE_W-1:0]          used;
    bit [SPACE_W-1:0]          cap;
    bit [MINOBJ_W-1:0]         min_obj;
    bit signed [OBJ_W-1:0]     max_obj;
    bit signed [OBJ_W-1:0]     obj_size;
    bit [HDR_W-1:0]            hdr;
  } dir_word_t;

  typedef struct packed {
    bit             found;
    bit [DIR_W-1:0] dir;
  } choice_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_req_type;
  logic [DIR_W-1:0] in_dir_index;
  logic in_read_only;
  logic in_accepts;
  logic signed [LOAD_W-1:0] in_load;
  logic [SPACE_W-1:0] in_used_space;
  logic [SPACE_W-1:0] in_capacity;
  logic [MINOBJ_W-1:0] in_min_object;
  logic signed [OBJ_W-1:0] in_max_object;
  logic signed [OBJ_W-1:0] in_object_size;
  logic [HDR_W-1:0] in_header_size;
  logic out_strobe;
  logic out_found;
  logic [DIR_W-1:0] out_chosen_dir;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // scoreboard copy of the table, pointer and registers
  bit                     tbl_ro   [NUM_DIRS];
  bit                     tbl_acc  [NUM_DIRS];
  bit signed [LOAD_W-1:0] tbl_load [NUM_DIRS];
  bit [SPACE_W-1:0]       tbl_used [NUM_DIRS];
  bit [SPACE_W-1:0]       tbl_cap  [NUM_DIRS];
  bit [MINOBJ_W-1:0]      tbl_min  [NUM_DIRS];
  bit signed [OBJ_W-1:0]  tbl_max  [NUM_DIRS];
  int                     rr_pos    = 0;
  logic                   sel_mode  = MODE_LEAST_LOAD;
  bit [ACT_W-1:0]         act_count = ACTIVE_RST;
  bit [RRLD_W-1:0]        rr_limit  = RR_MAX_LOAD_RST;

  choice_t awaited_choices [$];

  int idle_pct     = 0;
  int quiet_cycles = 0;
  int n_errors     = 0;
  int n_writes     = 0;
  int n_selects    = 0;
  int n_found      = 0;
  int n_reg_writes = 0;

  store_dir_selector_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_dir_index   (in_dir_index),
    .in_read_only   (in_read_only),
    .in_accepts     (in_accepts),
    .in_load        (in_load),
    .in_used_space  (in_used_space),
    .in_capacity    (in_capacity),
    .in_min_object  (in_min_object),
    .in_max_object  (in_max_object),
    .in_object_size (in_object_size),
    .in_header_size (in_header_size),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_chosen_dir (out_chosen_dir),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit dir_fits(int i, longint size);
    longint lo;
    longint hi;
    lo = longint'(tbl_min[i]);
    hi = longint'(tbl_max[i]);
    if (tbl_ro[i] || !tbl_acc[i]) return 1'b0;
    if (tbl_used[i] > tbl_cap[i]) return 1'b0;
    if (size == -1) return hi == -1;
    return lo <= size && (hi > size || hi == -1);
  endfunction

  function automatic choice_t choose_dir(dir_word_t w);
    choice_t r;
    int      n;
    int      best;
    bit      have;
    longint  size;
    longint  ld;
    longint  fr;
    longint  mx;
    longint  best_load;
    longint  best_max;
    longint  best_free;
    r = '0;
    best = -1;
    n = (act_count > NUM_DIRS) ? NUM_DIRS : int'(act_count);
    size = longint'(w.obj_size);
    if (sel_mode == MODE_ROUND_ROBIN) begin
      // n + 1 looks, pointer advances before each
      if (n != 0) begin
        for (int k = 0; k <= n; k++) begin
          rr_pos++;
          if (rr_pos >= n) rr_pos = 0;
          ld = longint'(tbl_load[rr_pos]);
          if (dir_fits(rr_pos, size) && ld >= 0 && ld <= longint'(rr_limit)) begin
            best = rr_pos;
            break;
          end
        end
      end
    end else begin
      if (size != -1) size += longint'(w.hdr);
      have = 1'b0;
      best_load = 0;
      best_max = -1;
      best_free = 0;
      for (int i = 0; i < n; i++) begin
        ld = longint'(tbl_load[i]);
        if (ld < 0 || ld > longint'(LL_MAX_LOAD)) continue;
        if (!dir_fits(i, size)) continue;
        if (have && ld > best_load) continue;
        fr = longint'(tbl_cap[i]) - longint'(tbl_used[i]);
        mx = longint'(tbl_max[i]);
        // equal load: skip a looser size limit or less free space
        if (have && ld == best_load) begin
          if (best_max != -1 && (mx > best_max || mx == -1)) continue;
          if (fr < best_free) continue;
        end
        have = 1'b1;
        best_load = ld;
        best_max = mx;
        best_free = fr;
        best = i;
      end
    end
    if (best >= 0) begin
      r.found = 1'b1;
      r.dir = DIR_W'(best);
    end
    return r;
  endfunction

  function automatic void apply_word(dir_word_t w);
    if (w.req == REQ_WRITE) begin
      tbl_ro[w.dir]   = w.ro;
      tbl_acc[w.dir]  = w.acc;
      tbl_load[w.dir] = w.load;
      tbl_used[w.dir] = w.used;
      tbl_cap[w.dir]  = w.cap;
      tbl_min[w.dir]  = w.min_obj;
      tbl_max[w.dir]  = w.max_obj;
      n_writes++;
    end else begin
      awaited_choices.push_back(choose_dir(w));
      n_selects++;
    end
  endfunction

  function automatic dir_word_t entry_word(int dir, bit ro, bit acc, longint load,
                                           longint unsigned used, longint unsigned cap,
                                           longint min_obj, longint max_obj);
    dir_word_t w;
    w.req      = REQ_WRITE;
    w.dir      = DIR_W'(dir);
    w.ro       = ro;
    w.acc      = acc;
    w.load     = load;
    w.used     = used;
    w.cap      = cap;
    w.min_obj  = min_obj;
    w.max_obj  = max_obj;
    w.obj_size = '0;
    w.hdr      = '0;
    return w;
  endfunction

  function automatic dir_word_t pick_word(longint size, int hdr);
    dir_word_t w;
    w = entry_word(0, 1'b0, 1'b0, 0, 0, 0, 0, 0);
    w.req      = REQ_SELECT;
    w.obj_size = size;
    w.hdr      = hdr;
    return w;
  endfunction

  function automatic dir_word_t random_word();
    dir_word_t         w;
    bit [MINOBJ_W-1:0] wide_a;
    bit [MINOBJ_W-1:0] wide_b;
    bit [MINOBJ_W-1:0] wide_c;
    int unsigned       roll;
    int unsigned       cap;
    wide_a = {$urandom, $urandom};
    wide_b = {$urandom, $urandom};
    wide_c = {$urandom, $urandom};
    w.req      = ($urandom_range(99) < 40) ? REQ_WRITE : REQ_SELECT;
    w.dir      = DIR_W'($urandom_range(NUM_DIRS - 1));
    w.ro       = $urandom_range(1);
    w.acc      = $urandom_range(1);
    w.load     = ($urandom_range(19) == 0) ? -1 : $urandom_range(65535);
    w.used     = $urandom;
    w.cap      = $urandom;
    w.min_obj  = wide_a;
    w.max_obj  = ($urandom_range(9) == 0) ? -1 : {1'b0, wide_b};
    w.obj_size = ($urandom_range(9) == 0) ? -1 : {1'b0, wide_c};
    w.hdr      = $urandom_range(65535);
    if ($urandom_range(99) < 85) begin
      // plausible entries and sizes so that choices and ties really happen
      w.ro  = ($urandom_range(99) < 8);
      w.acc = ($urandom_range(99) < 92);
      roll = $urandom_range(99);
      if (roll < 55) w.load = $urandom_range(3);
      else if (roll < 80) w.load = $urandom_range(1000);
      else if (roll < 90) w.load = $urandom_range(65535, 1001);
      else if (roll < 95) w.load = -1;
      cap = 100 * $urandom_range(3, 1);
      roll = $urandom_range(99);
      if (roll < 70) begin
        w.cap  = cap;
        w.used = $urandom_range(1) ? 0 : 50;
      end else if (roll < 85) begin
        w.used = w.cap;
      end else if (roll < 95) begin
        w.cap  = cap;
        w.used = cap + 1;
      end
      roll = $urandom_range(99);
      if (roll < 30) w.min_obj = '0;
      else if (roll < 90) w.min_obj = $urandom_range(100);
      roll = $urandom_range(99);
      if (roll < 35) w.max_obj = -1;
      else if (roll < 75) w.max_obj = 1000 * $urandom_range(5, 1);
      else if (roll < 90) w.max_obj = $urandom_range(20000, 100);
      roll = $urandom_range(99);
      if (roll < 20) w.obj_size = -1;
      else if (roll < 80) w.obj_size = $urandom_range(6000);
      else if (roll < 90) w.obj_size = 48'h7FFF_FFFF_FFFF - $urandom_range(3);
      roll = $urandom_range(99);
      if (roll < 60) w.hdr = $urandom_range(100);
      else if (roll < 70) w.hdr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return w;
  endfunction

  // hand one word to the block; start stays high after acceptance
  task automatic send_word(input dir_word_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start          <= 1'b1;
    in_req_type    <= w.req;
    in_dir_index   <= w.dir;
    in_read_only   <= w.ro;
    in_accepts     <= w.acc;
    in_load        <= w.load;
    in_used_space  <= w.used;
    in_capacity    <= w.cap;
    in_min_object  <= w.min_obj;
    in_max_object  <= w.max_obj;
    in_object_size <= w.obj_size;
    in_header_size <= w.hdr;
    do @(posedge clk); while (busy);
    apply_word(w);
  endtask

  // drop start and hold until every pending choice is back and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (awaited_choices.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic mode, input int act, input int rr);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{CFG_SELECT_MODE, CFG_ACTIVE_COUNT, CFG_RR_MAX_LOAD};
    vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(act), CFG_DATA_W'(rr)};
    settle();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (regs[k])
        CFG_SELECT_MODE:  sel_mode  = vals[k][0];
        CFG_ACTIVE_COUNT: act_count = vals[k][ACT_W-1:0];
        CFG_RR_MAX_LOAD:  rr_limit  = vals[k][RRLD_W-1:0];
        default: ;
      endcase
      n_reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // fill the whole table, then select with the reset register values
  task automatic test_reset_state();
    for (int i = 0; i < NUM_DIRS; i++) begin
      send_word(entry_word(i, 1'b0, 1'b1, 500 + i, 0, 100 + i, 0, -1));
    end
    send_word(pick_word(-1, 0));
    send_word(pick_word(12345, 65535));
  endtask

  task automatic test_least_load();
    configure(MODE_LEAST_LOAD, NUM_DIRS, 1000);
    send_word(entry_word(0, 1'b0, 1'b1, -1, 0, 100, 0, -1));
    send_word(entry_word(1, 1'b0, 1'b1, 1001, 0, 100, 0, -1));
    send_word(entry_word(2, 1'b1, 1'b1, 0, 0, 100, 0, -1));
    send_word(entry_word(3, 1'b0, 1'b0, 0, 0, 100, 0, -1));
    send_word(entry_word(4, 1'b0, 1'b1, 0, 32'hFFFF_FFFF, 0, 0, -1));
    send_word(pick_word(-1, 0));
    // four-way tie on load: size limit and free space decide
    send_word(entry_word(6, 1'b0, 1'b1, 7, 0, 100, 0, 5000));
    send_word(entry_word(7, 1'b0, 1'b1, 7, 50, 100, 0, 4000));
    send_word(entry_word(8, 1'b0, 1'b1, 7, 20, 100, 0, 4000));
    send_word(entry_word(9, 1'b0, 1'b1, 7, 0, 32'hFFFF_FFFF, 0, -1));
    send_word(pick_word(10, 0));
    send_word(pick_word(3990, 20));
    send_word(entry_word(10, 1'b0, 1'b1, 1000, 0, 0, 47'h7FFF_FFFF_FFFE,
                         48'h7FFF_FFFF_FFFF));
    send_word(pick_word(48'h7FFF_FFFF_FFFE - 65535, 65535));
    send_word(pick_word(0, 0));
    configure(MODE_LEAST_LOAD, 0, 1000);
    send_word(pick_word(10, 0));
  endtask

  task automatic test_round_robin();
    configure(MODE_ROUND_ROBIN, NUM_DIRS, 0);
    send_word(pick_word(10, 0));
    configure(MODE_ROUND_ROBIN, NUM_DIRS, 65535);
    send_word(entry_word(11, 1'b0, 1'b1, 65535, 0, 100, 0, -1));
    repeat (3) send_word(pick_word(10, 0));
    send_word(pick_word(48'h7FFF_FFFF_FFFE, 65535));
    configure(MODE_ROUND_ROBIN, 0, 1000);
    send_word(pick_word(10, 0));
    configure(MODE_ROUND_ROBIN, 31, 1000);
    repeat (2) send_word(pick_word(-1, 0));
    // pointer sits above the new count and must wrap
    configure(MODE_ROUND_ROBIN, 3, 1000);
    repeat (2) send_word(pick_word(10, 0));
  endtask

  task automatic test_random_traffic();
    logic mode_plan [8] = '{MODE_LEAST_LOAD, MODE_ROUND_ROBIN, MODE_ROUND_ROBIN,
                            MODE_LEAST_LOAD, MODE_ROUND_ROBIN, MODE_LEAST_LOAD,
                            MODE_ROUND_ROBIN, MODE_LEAST_LOAD};
    int   act_plan  [8] = '{16, 16, 1, -1, 31, 1, -1, 16};
    int   rr_plan   [8] = '{1000, 65535, 0, -1, 1000, -1, -1, 65535};
    int   idle_plan [3] = '{0, 54, 16};
    int   act;
    int   rr;
    for (int p = 0; p < 8; p++) begin
      act = (act_plan[p] < 0) ? $urandom_range(15, 2) : act_plan[p];
      rr  = (rr_plan[p] < 0) ? $urandom_range(65535) : rr_plan[p];
      configure(mode_plan[p], act, rr);
      idle_pct = idle_plan[p % 3];
      for (int j = 0; j < 150; j++) begin
        if ($urandom_range(99) == 0) settle();
        send_word(random_word());
      end
    end
    idle_pct = 0;
  endtask

  // result monitor
  always @(posedge clk) begin
    choice_t want;
    if (rst_n && out_strobe) begin
      if (awaited_choices.size() == 0) begin
        $display("%0t: unexpected result found=%0d chosen_dir=%0d",
                 $time, out_found, out_chosen_dir);
        n_errors++;
      end else begin
        want = awaited_choices.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
          n_errors++;
        end
        if (out_chosen_dir !== want.dir) begin
          $display("%0t: chosen_dir expected %0d actual %0d",
                   $time, want.dir, out_chosen_dir);
          n_errors++;
        end
        if (want.found) n_found++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("store_dir_selector_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_WRITE;
    in_dir_index   <= '0;
    in_read_only   <= 1'b0;
    in_accepts     <= 1'b0;
    in_load        <= '0;
    in_used_space  <= '0;
    in_capacity    <= '0;
    in_min_object  <= '0;
    in_max_object  <= '0;
    in_object_size <= '0;
    in_header_size <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_SELECT_MODE;
    cfg_data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_least_load();
    test_round_robin();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);
    $display("summary: %0d table writes, %0d selections, %0d with a directory found",
             n_writes, n_selects, n_found);
    $display("summary: %0d register writes over both modes, counts 0..31, limits 0..65535",
             n_reg_writes);
    if (n_errors == 0) $display("store_dir_selector_core_tb: PASS");
    else $display("store_dir_selector_core_tb: FAIL");
    $finish;
  end

endmodule
